@@ src/bst_pkg.sv @@
// shared types and constants of the bencode stream tokenizer
// no dependencies
package bst_pkg;

	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_L = 8'h6c;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;

	localparam logic [63:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		EV_PENDING = 3'd0,
		EV_INT     = 3'd1,
		EV_STR     = 3'd2,
		EV_BYTE    = 3'd3,
		EV_LIST    = 3'd4,
		EV_DICT    = 3'd5,
		EV_CLOSE   = 3'd6
	} event_t;

	typedef enum logic [3:0] {
		ERR_NONE     = 4'd0,
		ERR_START    = 4'd1,
		ERR_LZERO    = 4'd2,
		ERR_NEGZERO  = 4'd3,
		ERR_NODIGIT  = 4'd4,
		ERR_NUMBYTE  = 4'd5,
		ERR_COLON    = 4'd6,
		ERR_TRUNC    = 4'd7,
		ERR_DEEP     = 4'd8,
		ERR_INTOVF   = 4'd9,
		ERR_LENOVF   = 4'd10
	} err_t;

	typedef enum logic [5:0] {
		M_EXPECT  = 6'b000001,
		M_INT     = 6'b000010,
		M_STRLEN  = 6'b000100,
		M_STRDATA = 6'b001000,
		M_DONE    = 6'b010000,
		M_ERROR   = 6'b100000
	} mode_t;

	localparam logic [1:0] SLOT_LIST = 2'd0;
	localparam logic [1:0] SLOT_KEY = 2'd1;
	localparam logic [1:0] SLOT_VAL = 2'd2;

	typedef enum logic [2:0] {
		C_DIGIT = 3'd0,
		C_E     = 3'd1,
		C_I     = 3'd2,
		C_OPEN  = 3'd3,
		C_COLON = 3'd4,
		C_MINUS = 3'd5,
		C_OTHER = 3'd6
	} cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [3:0] digit;
		cls_t cls;
		logic first_byte;
		logic end_of_buffer;
	} tok_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic first_byte;
		logic end_of_buffer;
	} in_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [63:0] value;
		logic is_key;
		logic [5:0] depth;
		logic [3:0] error_code;
		logic done_res;
	} out_t;

endpackage

@@ src/bst_stream_if.sv @@
// valid/ready channel carrying one payload
// depends on bst_pkg types through the type parameter
interface bst_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ src/bst_front.sv @@
// front: accepts bytes and classifies them into tokens
// depends on bst_pkg
module bst_front (
	input logic clk,
	input logic arst_n,
	bst_stream_if.sink in_ch,
	output logic tok_valid,
	output bst_pkg::tok_t tok,
	input logic tok_ready
);
	import bst_pkg::*;

	tok_t tok_q;
	logic valid_q;
	tok_t cur;

	always_comb begin
		cur.data_byte = in_ch.payload.data_byte;
		cur.first_byte = in_ch.payload.first_byte;
		cur.end_of_buffer = in_ch.payload.end_of_buffer;
		cur.digit = 4'(in_ch.payload.data_byte - CH_ZERO);
		if (in_ch.payload.data_byte >= CH_ZERO && in_ch.payload.data_byte <= 8'h39) begin
			cur.cls = C_DIGIT;
		end else if (in_ch.payload.data_byte == CH_E) begin
			cur.cls = C_E;
		end else if (in_ch.payload.data_byte == CH_I) begin
			cur.cls = C_I;
		end else if (in_ch.payload.data_byte == CH_L || in_ch.payload.data_byte == CH_D) begin
			cur.cls = C_OPEN;
		end else if (in_ch.payload.data_byte == CH_COLON) begin
			cur.cls = C_COLON;
		end else if (in_ch.payload.data_byte == CH_MINUS) begin
			cur.cls = C_MINUS;
		end else begin
			cur.cls = C_OTHER;
		end
	end

	assign in_ch.ready = !valid_q || tok_ready;
	assign tok_valid = valid_q;
	assign tok = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			tok_q <= cur;
		end
	end
endmodule

@@ src/bst_fifo.sv @@
// short token queue between front and back
// depends on bst_pkg
module bst_fifo (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input bst_pkg::tok_t in_tok,
	output logic out_valid,
	input logic out_ready,
	output bst_pkg::tok_t out_tok
);
	import bst_pkg::*;

	tok_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_tok = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_tok;
	end
endmodule

@@ src/bst_back.sv @@
// back: parse state machine, container stack and output register
// depends on bst_pkg
module bst_back #(
	parameter int MAX_DEPTH = 32,
	parameter int LENGTH_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic [5:0] max_nesting,
	input logic tok_valid,
	output logic tok_ready,
	input bst_pkg::tok_t tok,
	bst_stream_if.source out_ch
);
	import bst_pkg::*;

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam logic [63:0] LEN_MAX = 64'((65'd1 << LENGTH_BITS) - 65'd1);

	mode_t mode_q, nmode;
	logic [63:0] acc_q, nacc;
	logic neg_q, nneg;
	logic [1:0] dcnt_q, ndcnt;
	logic lz_q, nlz;
	logic [LENGTH_BITS-1:0] rem_q, nrem;
	logic [DW-1:0] dep_q, ndep;
	logic [3:0] err_q, nerr;
	logic [1:0] stk_q [MAX_DEPTH];
	logic [1:0] top_q;

	logic ovalid_q;
	out_t out_q;
	logic take;

	mode_t m;
	logic [DW-1:0] dp;
	logic [1:0] top;
	logic [63:0] lim, d64, acc10, rem10;
	logic [9:0] limit;
	logic [2:0] ev;
	logic [63:0] val;
	logic key, fin, push, stk_wr;
	logic [AW-1:0] stk_a;
	logic [1:0] stk_d;

	assign tok_ready = !ovalid_q || out_ch.ready;
	assign take = tok_valid && tok_ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.payload = out_q;

	always_comb begin
		m = tok.first_byte ? M_EXPECT : mode_q;
		dp = tok.first_byte ? '0 : dep_q;
		top = (dp == '0) ? 2'd3 : top_q;
		nmode = m;
		nacc = acc_q;
		nneg = neg_q;
		ndcnt = tok.first_byte ? 2'd0 : dcnt_q;
		nlz = tok.first_byte ? 1'b0 : lz_q;
		nrem = tok.first_byte ? '0 : rem_q;
		ndep = dp;
		nerr = tok.first_byte ? 4'd0 : err_q;
		ev = EV_PENDING;
		val = '0;
		key = 1'b0;
		fin = 1'b0;
		push = 1'b0;
		d64 = 64'(tok.digit);
		lim = neg_q ? NEG_MAX : POS_MAX;
		acc10 = (acc_q << 3) + (acc_q << 1);
		rem10 = (64'(rem_q) << 3) + (64'(rem_q) << 1);
		limit = (10'(max_nesting) < 10'(MAX_DEPTH)) ? 10'(max_nesting) : 10'(MAX_DEPTH);
		case (m)
			M_EXPECT: begin
				if (tok.cls == C_DIGIT) begin
					nrem = LENGTH_BITS'(tok.digit);
					ndcnt = 2'd1;
					nlz = tok.digit == 4'd0;
					nmode = M_STRLEN;
				end else if (tok.cls == C_E && (top == SLOT_LIST || top == SLOT_KEY)) begin
					ndep = dp - DW'(1);
					ev = EV_CLOSE;
					fin = 1'b1;
				end else if (top != SLOT_KEY && tok.cls == C_I) begin
					nacc = '0;
					nneg = 1'b0;
					ndcnt = 2'd0;
					nlz = 1'b0;
					nmode = M_INT;
				end else if (top != SLOT_KEY && tok.cls == C_OPEN) begin
					if (10'(dp) >= limit) begin
						nerr = ERR_DEEP;
						nmode = M_ERROR;
					end else begin
						push = 1'b1;
						ndep = dp + DW'(1);
						ev = (tok.data_byte == CH_L) ? EV_LIST : EV_DICT;
					end
				end else begin
					nerr = ERR_START;
					nmode = M_ERROR;
				end
			end
			M_INT: begin
				if (tok.cls == C_DIGIT) begin
					if (dcnt_q != 2'd0 && lz_q) begin
						nerr = ERR_LZERO;
						nmode = M_ERROR;
					end else if (acc_q > POS_MAX / 10 + 64'd1 ||
							acc10 > lim - d64) begin
						nerr = ERR_INTOVF;
						nmode = M_ERROR;
					end else begin
						if (dcnt_q == 2'd0) nlz = tok.digit == 4'd0;
						nacc = acc10 + d64;
						if (dcnt_q != 2'd3) ndcnt = dcnt_q + 2'd1;
					end
				end else if (tok.cls == C_MINUS && dcnt_q == 2'd0 && !neg_q) begin
					nneg = 1'b1;
				end else if (tok.cls == C_E) begin
					if (dcnt_q == 2'd0) begin
						nerr = ERR_NODIGIT;
						nmode = M_ERROR;
					end else if (neg_q && acc_q == '0) begin
						nerr = ERR_NEGZERO;
						nmode = M_ERROR;
					end else begin
						ev = EV_INT;
						val = neg_q ? -acc_q : acc_q;
						fin = 1'b1;
					end
				end else begin
					nerr = ERR_NUMBYTE;
					nmode = M_ERROR;
				end
			end
			M_STRLEN: begin
				if (tok.cls == C_DIGIT) begin
					if (lz_q) begin
						nerr = ERR_LZERO;
						nmode = M_ERROR;
					end else if (64'(rem_q) > LEN_MAX / 10 || rem10 > LEN_MAX - d64) begin
						nerr = ERR_LENOVF;
						nmode = M_ERROR;
					end else begin
						nrem = LENGTH_BITS'(rem10 + d64);
						if (dcnt_q != 2'd3) ndcnt = dcnt_q + 2'd1;
					end
				end else if (tok.cls == C_COLON) begin
					ev = EV_STR;
					val = 64'(rem_q);
					key = top == SLOT_KEY;
					if (rem_q == '0) fin = 1'b1;
					else nmode = M_STRDATA;
				end else begin
					nerr = ERR_COLON;
					nmode = M_ERROR;
				end
			end
			M_STRDATA: begin
				ev = EV_BYTE;
				val = 64'(tok.data_byte);
				key = top == SLOT_KEY;
				nrem = rem_q - LENGTH_BITS'(1);
				if (nrem == '0) fin = 1'b1;
			end
			default: begin
			end
		endcase
		stk_wr = 1'b0;
		stk_a = '0;
		stk_d = SLOT_LIST;
		if (push) begin
			stk_wr = 1'b1;
			stk_a = AW'(dp);
			stk_d = (tok.data_byte == CH_L) ? SLOT_LIST : SLOT_KEY;
		end
		if (fin) begin
			if (ndep == '0) begin
				nmode = M_DONE;
			end else begin
				nmode = M_EXPECT;
				stk_a = AW'(ndep - DW'(1));
				if (ev == EV_CLOSE) begin
					if (stk_q[stk_a] != SLOT_LIST) begin
						stk_wr = 1'b1;
						stk_d = (stk_q[stk_a] == SLOT_KEY) ? SLOT_VAL : SLOT_KEY;
					end
				end else if (top != SLOT_LIST) begin
					stk_wr = 1'b1;
					stk_d = (top == SLOT_KEY) ? SLOT_VAL : SLOT_KEY;
				end
			end
		end
		if (tok.end_of_buffer && nmode != M_DONE && nmode != M_ERROR) begin
			nerr = ERR_TRUNC;
			nmode = M_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_EXPECT;
			acc_q <= '0;
			neg_q <= 1'b0;
			dcnt_q <= 2'd0;
			lz_q <= 1'b0;
			rem_q <= '0;
			dep_q <= '0;
			err_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_ch.ready) ovalid_q <= 1'b0;
			if (take) begin
				mode_q <= nmode;
				acc_q <= nacc;
				neg_q <= nneg;
				dcnt_q <= ndcnt;
				lz_q <= nlz;
				rem_q <= nrem;
				dep_q <= ndep;
				err_q <= nerr;
				ovalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (stk_wr) stk_q[stk_a] <= stk_d;
			if (ndep != '0) begin
				if (stk_wr && stk_a == AW'(ndep - DW'(1))) top_q <= stk_d;
				else top_q <= stk_q[AW'(ndep - DW'(1))];
			end
			out_q.event_res <= ev;
			out_q.value <= val;
			out_q.is_key <= key;
			out_q.depth <= 6'(ndep);
			out_q.error_code <= nerr;
			out_q.done_res <= nmode == M_DONE;
		end
	end
endmodule

@@ src/bencode_stream_tokenizer.sv @@
// path from byte transfer to event: front register, queue, output register
// throughput: one byte per cycle while out_ch is ready; output back-pressure stalls the chain
// reset: arst_n clears parse state, nesting limit returns to 32; stack entries are not cleared
// top level of the bencode stream tokenizer
// depends on bst_pkg, bst_stream_if, bst_front, bst_fifo, bst_back
module bencode_stream_tokenizer #(
	parameter int MAX_DEPTH = 32,
	parameter int LENGTH_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [5:0] cfg_wdata,
	bst_stream_if.sink in_ch,
	bst_stream_if.source out_ch
);
	import bst_pkg::*;

	logic [5:0] max_nesting_q;
	logic f_valid, f_ready, b_valid, b_ready;
	tok_t f_tok, b_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_nesting_q <= 6'd32;
		else if (cfg_we) max_nesting_q <= cfg_wdata;
	end

	bst_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.tok_valid(f_valid), .tok(f_tok), .tok_ready(f_ready)
	);

	bst_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_tok(f_tok),
		.out_valid(b_valid), .out_ready(b_ready), .out_tok(b_tok)
	);

	bst_back #(.MAX_DEPTH(MAX_DEPTH), .LENGTH_BITS(LENGTH_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .max_nesting(max_nesting_q),
		.tok_valid(b_valid), .tok_ready(b_ready), .tok(b_tok), .out_ch(out_ch)
	);
endmodule
